### rtl/unordered_max_priority_queue_assert.svh
// Assertion macros for the unordered max priority queue.
`ifndef UNORDERED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define UNORDERED_MAX_PRIORITY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define UMPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("umpq assertion failed");
`define UMPQ_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("umpq assertion failed");
`else
`define UMPQ_ASSERT(lbl, prop)
`define UMPQ_ASSERT_NR(lbl, prop)
`endif

`endif

### rtl/umpq_pkg.sv
// Package: payload types, codes and defaults for the max priority queue.
package umpq_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned KEY_IO_W = 32;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_IO_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [KEY_IO_W-1:0] max_key;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } out_t;

endpackage

### rtl/umpq_cell.sv
// One storage cell: holds a key and forwards the running-maximum scan token.
module umpq_cell import umpq_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CW-1:0]        count_i,
  input  logic                 wr_en_i,
  input  logic [IW-1:0]        wr_idx_i,
  input  logic [KEY_WIDTH-1:0] wr_key_i,
  input  logic                 tok_valid_i,
  input  logic [KEY_WIDTH-1:0] tok_best_key_i,
  input  logic [IW-1:0]        tok_best_idx_i,
  input  logic [KEY_WIDTH-1:0] tok_last_key_i,
  output logic                 tok_valid_o,
  output logic [KEY_WIDTH-1:0] tok_best_key_o,
  output logic [IW-1:0]        tok_best_idx_o,
  output logic [KEY_WIDTH-1:0] tok_last_key_o
);

  logic [KEY_WIDTH-1:0] key_q;
  logic                 tok_valid_q;
  logic [KEY_WIDTH-1:0] best_key_q, best_key_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [KEY_WIDTH-1:0] last_key_q, last_key_d;
  logic                 take;

  // strict compare: earlier maximum wins on ties
  assign take = (CW'(IDX) < count_i) && (tok_best_key_i < key_q);

  always_comb begin
    best_key_d = take ? key_q : tok_best_key_i;
    best_idx_d = take ? IW'(IDX) : tok_best_idx_i;
    last_key_d = (count_i == CW'(IDX + 1)) ? key_q : tok_last_key_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IW'(IDX))) begin
      key_q <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      best_key_q <= best_key_d;
      best_idx_q <= best_idx_d;
      last_key_q <= last_key_d;
    end
  end

  assign tok_valid_o    = tok_valid_q;
  assign tok_best_key_o = best_key_q;
  assign tok_best_idx_o = best_idx_q;
  assign tok_last_key_o = last_key_q;

endmodule

### rtl/unordered_max_priority_queue.sv
// Top level: bounded max priority queue over a chain of key cells.
//
// Usage: requests arrive on in_* (valid/ready), one result per request
// leaves on out_* (valid/ready). A transaction is taken on a rising edge
// with valid and ready both high.
// Insert, no-op and requests on an empty or full queue write their result
// to res_q on acceptance; from S_DONE it moves to the output register.
// Remove and peek launch a scan token through the CAPACITY cells, one cell
// a cycle; when it leaves the last cell the result goes to res_q, and from
// S_DONE it moves to the output register.
// A request is taken only in S_IDLE, so each one must reach the output
// register before the next request is taken.
// The output register lets a new request be taken while a result waits;
// a request that completes while the receiver stalls holds in its final
// state, and no further request is taken until the result moves on.
// Reset empties the queue (count zero) and clears all handshake state;
// stored keys are not cleared.
module unordered_max_priority_queue import umpq_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic               remove_q;
  out_t               res_q;
  out_t               out_q;
  logic               out_valid_q;

  logic                 accept;
  logic                 full;
  logic                 start;
  logic                 scan_done;
  logic [KEY_WIDTH-1:0] key_in;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [KEY_WIDTH-1:0] wr_key;

  logic                 tok_v    [0:CAPACITY];
  logic [KEY_WIDTH-1:0] tok_best [0:CAPACITY];
  logic [IW-1:0]        tok_idx  [0:CAPACITY];
  logic [KEY_WIDTH-1:0] tok_last [0:CAPACITY];
  logic [CAPACITY-1:0]  cell_v;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign key_in     = KEY_WIDTH'(in_i.key);
  assign start      = accept && (in_i.mode == MODE_REMOVE || in_i.mode == MODE_PEEK)
                      && (count_q != '0);
  assign scan_done  = (state_q == S_SCAN) && tok_v[CAPACITY];

  assign tok_v[0]    = start;
  assign tok_best[0] = '0;
  assign tok_idx[0]  = '0;
  assign tok_last[0] = '0;

  always_comb begin
    wr_en  = (accept && (in_i.mode == MODE_INSERT) && !full) || (scan_done && remove_q);
    wr_idx = (state_q == S_IDLE) ? IW'(count_q) : tok_idx[CAPACITY];
    wr_key = (state_q == S_IDLE) ? key_in : tok_last[CAPACITY];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    umpq_cell #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .count_i        (count_q),
      .wr_en_i        (wr_en),
      .wr_idx_i       (wr_idx),
      .wr_key_i       (wr_key),
      .tok_valid_i    (tok_v[i]),
      .tok_best_key_i (tok_best[i]),
      .tok_best_idx_i (tok_idx[i]),
      .tok_last_key_i (tok_last[i]),
      .tok_valid_o    (tok_v[i+1]),
      .tok_best_key_o (tok_best[i+1]),
      .tok_best_idx_o (tok_idx[i+1]),
      .tok_last_key_o (tok_last[i+1])
    );
    assign cell_v[i] = tok_v[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remove_q    <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.max_key <= '0;
            res_q.status  <= STATUS_DONE;
            res_q.count   <= COUNT_W'(count_q);
            res_q.is_empty <= (count_q == '0);
            state_q       <= S_DONE;
            unique case (in_i.mode) inside
              MODE_INSERT: begin
                if (full) begin
                  res_q.status <= STATUS_FULL;
                end else begin
                  count_q        <= count_q + CW'(1);
                  res_q.count    <= COUNT_W'(count_q + CW'(1));
                  res_q.is_empty <= 1'b0;
                end
              end
              MODE_REMOVE, MODE_PEEK: begin
                if (count_q == '0) begin
                  res_q.status <= STATUS_EMPTY;
                end else begin
                  remove_q <= (in_i.mode == MODE_REMOVE);
                  state_q  <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            res_q.max_key <= KEY_IO_W'(tok_best[CAPACITY]);
            res_q.status  <= STATUS_DONE;
            if (remove_q) begin
              count_q        <= count_q - CW'(1);
              res_q.count    <= COUNT_W'(count_q - CW'(1));
              res_q.is_empty <= (count_q == CW'(1));
            end else begin
              res_q.count    <= COUNT_W'(count_q);
              res_q.is_empty <= 1'b0;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "unordered_max_priority_queue_assert.svh"

  `UMPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
  `UMPQ_ASSERT(a_one_token, $onehot0(cell_v))
  `UMPQ_ASSERT(a_count_step, (count_q != $past(count_q)) |-> ((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))

endmodule

### tb/tb.sv
// Testbench for the unordered max priority queue: random and directed transactions, scoreboard.
`timescale 1ns / 100ps

module tb;
  import umpq_pkg::*;

  localparam logic [1:0] MODE_NOP  = 2'd3;
  localparam int unsigned CAP      = CAPACITY_DEF;
  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned LIMIT    = 300000;
  localparam int unsigned HOLD_AT  = 300;
  localparam int unsigned HOLD_LEN = 120;
  localparam int unsigned QUIET_LO = 500;
  localparam int unsigned QUIET_HI = 700;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  unordered_max_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  in_t         requests[$];
  int unsigned drain_marks[$];
  out_t        expected_results[$];

  logic [KEY_IO_W-1:0] key_mem [CAP];
  int unsigned key_cnt  = 0;
  int unsigned n_sent   = 0;
  int unsigned n_taken  = 0;
  int unsigned n_errors = 0;
  bit          req_fire = 1'b0;
  bit          held     = 1'b0;
  int unsigned hold_left = 0;

  // Queue behaviour: first largest key wins, last entry fills the freed slot.
  task automatic apply_request(input in_t req, output out_t res);
    int unsigned best;
    int unsigned last;
    res = '0;
    res.status = STATUS_DONE;
    case (req.mode)
      MODE_INSERT: begin
        if (key_cnt >= CAP) begin
          res.status = STATUS_FULL;
        end else begin
          key_mem[key_cnt] = req.key;
          key_cnt++;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (key_cnt == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < key_cnt; i++) begin
            if (key_mem[best] < key_mem[i]) best = i;
          end
          res.max_key = key_mem[best];
          if (req.mode == MODE_REMOVE) begin
            last = key_cnt - 1;
            key_mem[best] = key_mem[last];
            key_mem[last] = res.max_key;
            key_cnt = last;
          end
        end
      end
      default: ;
    endcase
    res.count    = COUNT_W'(key_cnt);
    res.is_empty = (key_cnt == 0);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result max_key=%h status=%0d count=%0d is_empty=%0d",
               $time, got.max_key, got.status, got.count, got.is_empty);
      n_errors++;
    end else begin
      want = expected_results.pop_front();
      if (got.max_key !== want.max_key) begin
        $display("%0t: max_key expected %h actual %h", $time, want.max_key, got.max_key);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        n_errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        n_errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty, got.is_empty);
        n_errors++;
      end
    end
  endtask

  function automatic bit quiet_spell();
    return n_taken >= QUIET_LO && n_taken < QUIET_HI;
  endfunction

  // Monitor: predict on request transactions, compare on result transactions.
  always @(posedge clk_i) begin
    out_t res;
    if (rst_ni) begin
      req_fire = in_valid_i && in_ready_o;
      if (req_fire) begin
        apply_request(in_i, res);
        expected_results.push_back(res);
        n_taken++;
      end
      if (out_valid_o && out_ready_i) check_result(out_o);
    end
  end

  // Driver
  always @(negedge clk_i) begin
    bit hold_back;
    if (rst_ni && (!in_valid_i || req_fire)) begin
      hold_back = 1'b0;
      if (drain_marks.size() != 0 && n_sent == drain_marks[0]) begin
        if (expected_results.size() != 0) hold_back = 1'b1;
        else void'(drain_marks.pop_front());
      end
      if (!quiet_spell() && $urandom_range(99) < 13) hold_back = 1'b1;
      if (requests.size() == 0 || hold_back) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_i       <= requests.pop_front();
        n_sent++;
      end
    end
  end

  // Result sink, with one long hold-off to back the queue up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!held && n_taken >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_spell() ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic in_t make_req(logic [1:0] mode, logic [KEY_IO_W-1:0] key);
    in_t r;
    r.mode = mode;
    r.key  = key;
    return r;
  endfunction

  function automatic logic [KEY_IO_W-1:0] random_key();
    case ($urandom_range(3))
      0: return KEY_IO_W'($urandom_range(7));
      1: return $urandom;
      2: return $urandom & 32'h0000_ffff;
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return '1;
          default: return KEY_IO_W'(1) << $urandom_range(KEY_IO_W - 1);
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned bias;
    int unsigned ins_pct;
    int unsigned r;
    int unsigned cycles;
    bit          timed_out;
    logic [1:0]  mode;

    // directed: empty queue, extremes, equal maxima, full queue, unused mode
    requests.push_back(make_req(MODE_PEEK,   32'hffff_ffff));
    requests.push_back(make_req(MODE_REMOVE, 32'h5a5a_5a5a));
    requests.push_back(make_req(MODE_NOP,    32'ha5a5_a5a5));
    requests.push_back(make_req(MODE_INSERT, 32'h0000_0000));
    requests.push_back(make_req(MODE_INSERT, 32'hffff_ffff));
    requests.push_back(make_req(MODE_INSERT, 32'h0000_0007));
    requests.push_back(make_req(MODE_INSERT, 32'hffff_ffff));
    requests.push_back(make_req(MODE_INSERT, 32'h8000_0000));
    requests.push_back(make_req(MODE_PEEK,   32'h0000_0000));
    for (int i = 0; i < 11; i++) begin
      requests.push_back(make_req(MODE_INSERT, i[0] ? 32'h5555_5555 : 32'haaaa_aaaa));
    end
    requests.push_back(make_req(MODE_INSERT, 32'h0000_0001));
    requests.push_back(make_req(MODE_NOP,    32'hffff_ffff));
    requests.push_back(make_req(MODE_REMOVE, 32'h0000_0000));
    requests.push_back(make_req(MODE_REMOVE, 32'hffff_ffff));
    requests.push_back(make_req(MODE_PEEK,   32'h1234_5678));
    drain_marks.push_back(requests.size());

    bias = 0;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) bias = $urandom_range(2);
      ins_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      r = $urandom_range(99);
      if (r < 2) mode = MODE_NOP;
      else if ($urandom_range(99) < ins_pct) mode = MODE_INSERT;
      else if ($urandom_range(3) == 0) mode = MODE_PEEK;
      else mode = MODE_REMOVE;
      requests.push_back(make_req(mode, random_key()));
      if (i == 800) drain_marks.push_back(requests.size());
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cycles = 0;
    timed_out = 1'b0;
    while (!(requests.size() == 0 && !in_valid_i && expected_results.size() == 0)) begin
      @(negedge clk_i);
      cycles++;
      if (cycles >= LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end
    if (!timed_out) repeat (CAP + 20) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      n_errors++;
    end

    if (n_errors == 0 && !timed_out) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/umpq_pkg.sv
rtl/umpq_cell.sv
rtl/unordered_max_priority_queue.sv
tb/tb.sv
